FILE: src/assert_macros.svh
// Assertion macros used by the tracker controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, disabled while rst is high; expects clk and rst in scope.
`define NPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication built on the plain check.
`define NPT_ASSERT_NXT(lbl, ante, cons, msg) \
  `NPT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: src/npt_pkg.sv
// Shared types, constants and control structs of the path point tracker.
package npt_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 6;
  localparam int CRD_W  = 32;
  localparam int CNT_W  = 7;
  localparam int Q_W    = 16;
  localparam int ST_W   = 2;
  localparam int MAG_W  = CRD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int NV_W   = 34;
  localparam int QB_W   = 15;
  localparam int UNIT_Q14 = 16384;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FN_WRITE = 2'd0;
  localparam func_t FN_READ  = 2'd1;
  localparam func_t FN_QUERY = 2'd2;

  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DIR_ZERO = 2'd1;
  localparam status_t ST_NRM_ZERO = 2'd2;

  typedef enum logic [1:0] {
    AS_IDX,
    AS_SCAN,
    AS_BEST,
    AS_NEXT
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      scan_inc;
    logic      cap_point;
    logic      cap_best;
    logic      cap_next;
    logic      nf_start;
    logic      nn_start;
    logic      cap_fwd;
    logic      st_dir;
    logic      nv_cap;
    logic      cap_nrm;
    logic      st_nrm;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  scan_last;
    logic  pipe_empty;
    logic  norm_done;
    logic  norm_zero;
  } sts_t;

endpackage

FILE: src/npt_ifs.sv
// Request and response channel interfaces of the path point tracker.
interface npt_req_if;
  import npt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [IDX_W-1:0]        point_index;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;
  modport source (output valid, func, point_index, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, func, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface npt_rsp_if;
  import npt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        closest_index;
  logic [IDX_W-1:0]        next_index;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;
  logic signed [Q_W-1:0]   forward_x;
  logic signed [Q_W-1:0]   forward_y;
  logic signed [Q_W-1:0]   forward_z;
  logic signed [Q_W-1:0]   normal_x;
  logic signed [Q_W-1:0]   normal_y;
  logic signed [Q_W-1:0]   normal_z;
  logic [ST_W-1:0]         status;
  modport source (output valid, closest_index, next_index, point_x, point_y, point_z,
                  forward_x, forward_y, forward_z, normal_x, normal_y, normal_z, status,
                  input ready);
  modport sink (input valid, closest_index, next_index, point_x, point_y, point_z,
                forward_x, forward_y, forward_z, normal_x, normal_y, normal_z, status,
                output ready);
endinterface

FILE: src/npt_ram.sv
// Generic simple dual-port RAM with registered read.
module npt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/npt_norm.sv
// Iterative Q2.14 vector normalizer: shift search, sum of squares, bitwise root.
module npt_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [npt_pkg::NV_W-1:0]  vin [3],
  output logic                             done,
  output logic                             zero,
  output logic signed [npt_pkg::Q_W-1:0]   q [3]
);
  import npt_pkg::*;

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SUM   = 6'b000100,
    N_SQ    = 6'b001000,
    N_MUL   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  nstate_t state;
  logic [NV_W-1:0] mag [3];
  logic            neg [3];
  logic [NV_W-1:0] l2;
  logic [31:0]     rhs [3];
  logic [QB_W-1:0] qm [3];
  logic [31:0]     tsq [3];
  logic            cok [3];
  logic [3:0]      bpos;
  logic            zero_r;

  logic [31:0]     esq [3];
  logic [QB_W-1:0] cand [3];
  logic [15:0]     tval [3];
  logic [31:0]     tsq_next [3];
  logic [65:0]     prod [3];
  logic [65:0]     rhs_w [3];
  logic [65:0]     tsq_w [3];
  logic [65:0]     l2_w;
  logic            any_hi;
  logic            all_zero;

  always_comb begin
    any_hi   = 1'b0;
    all_zero = 1'b1;
    l2_w     = 66'(l2);
    for (int i = 0; i < 3; i++) begin
      esq[i]      = mag[i][15:0] * mag[i][15:0];
      cand[i]     = qm[i] | (QB_W'(1) << bpos);
      tval[i]     = {cand[i], 1'b0} - 16'd1;
      tsq_next[i] = tval[i] * tval[i];
      tsq_w[i]    = 66'(tsq[i]);
      rhs_w[i]    = 66'({rhs[i], 30'b0});
      prod[i]     = tsq_w[i] * l2_w;
      any_hi      = any_hi | (|mag[i][NV_W-1:16]);
      all_zero    = all_zero & (mag[i] == '0);
      q[i]        = neg[i] ? -$signed({1'b0, qm[i]}) : $signed({1'b0, qm[i]});
    end
  end

  assign done = (state == N_DONE);
  assign zero = zero_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= N_IDLE;
      zero_r <= 1'b0;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            zero_r <= 1'b0;
            state  <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (all_zero) begin
            zero_r <= 1'b1;
            state  <= N_DONE;
          end else if (!any_hi) begin
            state <= N_SUM;
          end
        end
        N_SUM:  state <= N_SQ;
        N_SQ:   state <= N_MUL;
        N_MUL:  state <= (bpos == 4'd0) ? N_DONE : N_SQ;
        N_DONE: state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vin[i][NV_W-1];
            mag[i] <= vin[i][NV_W-1] ? (~vin[i] + 1'b1) : vin[i];
            qm[i]  <= '0;
          end
        end
      end
      N_SHIFT: begin
        if (any_hi) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end
      end
      N_SUM: begin
        l2   <= NV_W'(esq[0]) + NV_W'(esq[1]) + NV_W'(esq[2]);
        bpos <= 4'(QB_W - 1);
        for (int i = 0; i < 3; i++) begin
          rhs[i] <= esq[i];
          qm[i]  <= '0;
        end
      end
      N_SQ: begin
        for (int i = 0; i < 3; i++) begin
          tsq[i] <= tsq_next[i];
          cok[i] <= (int'(cand[i]) <= UNIT_Q14);
        end
      end
      N_MUL: begin
        // keep the candidate bit where the rounded quotient still fits
        for (int i = 0; i < 3; i++) begin
          if (cok[i] && (prod[i] <= rhs_w[i])) begin
            qm[i] <= cand[i];
          end
        end
        bpos <= bpos - 4'd1;
      end
      default: begin
      end
    endcase
  end
endmodule

FILE: src/npt_dp.sv
// Datapath: point store, distance scan pipeline, vector setup and result registers.
module npt_dp #(
  parameter int MAX_POINTS = npt_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [npt_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic [npt_pkg::FUNC_W-1:0]        in_func,
  input  logic [npt_pkg::IDX_W-1:0]         in_idx,
  input  logic signed [npt_pkg::CRD_W-1:0]  in_x,
  input  logic signed [npt_pkg::CRD_W-1:0]  in_y,
  input  logic signed [npt_pkg::CRD_W-1:0]  in_z,
  input  npt_pkg::cmd_t                     cmd,
  output npt_pkg::sts_t                     sts,
  output logic [npt_pkg::IDX_W-1:0]         closest_index,
  output logic [npt_pkg::IDX_W-1:0]         next_index,
  output logic signed [npt_pkg::CRD_W-1:0]  point_x,
  output logic signed [npt_pkg::CRD_W-1:0]  point_y,
  output logic signed [npt_pkg::CRD_W-1:0]  point_z,
  output logic signed [npt_pkg::Q_W-1:0]    forward_x,
  output logic signed [npt_pkg::Q_W-1:0]    forward_y,
  output logic signed [npt_pkg::Q_W-1:0]    forward_z,
  output logic signed [npt_pkg::Q_W-1:0]    normal_x,
  output logic signed [npt_pkg::Q_W-1:0]    normal_y,
  output logic signed [npt_pkg::Q_W-1:0]    normal_z,
  output logic [npt_pkg::ST_W-1:0]          status
);
  import npt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = 3 * CRD_W;

  logic [CNT_W-1:0]        cnt_reg;
  func_t                   func_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    idx_ok;
  logic signed [CRD_W-1:0] crd [3];
  logic [AW-1:0]           k;
  logic                    s0_v, s1_v, s2_v;
  logic [AW-1:0]           s0_k, s1_k, s2_k;
  logic [MAG_W-1:0]        s1_m [3];
  logic [SQ_W-1:0]         s2_sq [3];
  logic [AW-1:0]           best_k;
  logic [SUM_W-1:0]        best_d;
  logic signed [CRD_W-1:0] pb [3];
  logic signed [CRD_W-1:0] pn [3];
  logic signed [NV_W-1:0]  nv [3];
  logic [IDX_W-1:0]        res_closest, res_next;
  logic signed [CRD_W-1:0] res_p [3];
  logic signed [Q_W-1:0]   res_f [3];
  logic signed [Q_W-1:0]   res_n [3];
  status_t                 res_st;

  logic [RW-1:0]           rdata;
  logic [AW-1:0]           raddr, waddr, idx_addr, last, nxt;
  logic                    in_idx_ok, ram_we;
  logic [AW+IDX_W-1:0]     in_wide, idx_wide, best_wide, nxt_wide;
  logic [CW-1:0]           cnt_act, cnt_m1;
  logic [CW+CNT_W-1:0]     cnt_wide;
  logic [CW+AW-1:0]        last_wide;
  logic signed [CRD_W-1:0] rp [3];
  logic [MAG_W-1:0]        dif [3];
  logic [MAG_W-1:0]        mag [3];
  logic [SQ_W-1:0]         sq [3];
  logic [SUM_W-1:0]        dsum;
  logic signed [NV_W-1:0]  dir [3];
  logic signed [NV_W-1:0]  nin [3];
  logic signed [31:0]      pxy, pxx, pzz, pyz;
  logic                    n_done, n_zero;
  logic signed [Q_W-1:0]   nq [3];

  // active point count: zero reads as one, saturate at the store depth
  always_comb begin
    cnt_wide = {{CW{1'b0}}, cnt_reg};
    if (cnt_reg == '0) begin
      cnt_act = CW'(1);
    end else if (int'(cnt_reg) > MAX_POINTS) begin
      cnt_act = CW'(MAX_POINTS);
    end else begin
      cnt_act = cnt_wide[CW-1:0];
    end
    cnt_m1    = cnt_act - CW'(1);
    last_wide = {{AW{1'b0}}, cnt_m1};
    last      = last_wide[AW-1:0];
  end

  assign in_wide   = {{AW{1'b0}}, in_idx};
  assign idx_wide  = {{AW{1'b0}}, idx_r};
  assign waddr     = in_wide[AW-1:0];
  assign idx_addr  = idx_wide[AW-1:0];
  assign in_idx_ok = (int'(in_idx) < MAX_POINTS);
  assign ram_we    = cmd.load && (in_func == FN_WRITE) && in_idx_ok;
  assign nxt       = (best_k == last) ? '0 : best_k + 1'b1;
  assign best_wide = {{IDX_W{1'b0}}, best_k};
  assign nxt_wide  = {{IDX_W{1'b0}}, nxt};

  always_comb begin
    case (cmd.addr_sel)
      AS_IDX:  raddr = idx_addr;
      AS_SCAN: raddr = k;
      AS_BEST: raddr = best_k;
      AS_NEXT: raddr = nxt;
      default: raddr = idx_addr;
    endcase
  end

  npt_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_x, in_y, in_z}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    dsum = '0;
    pxy  = res_f[0] * res_f[1];
    pxx  = res_f[0] * res_f[0];
    pzz  = res_f[2] * res_f[2];
    pyz  = res_f[1] * res_f[2];
    for (int i = 0; i < 3; i++) begin
      rp[i]  = $signed(rdata[(2-i)*CRD_W +: CRD_W]);
      dif[i] = {crd[i][CRD_W-1], crd[i]} - {rp[i][CRD_W-1], rp[i]};
      mag[i] = dif[i][MAG_W-1] ? (~dif[i] + 1'b1) : dif[i];
      sq[i]  = s1_m[i] * s1_m[i];
      dsum   = dsum + SUM_W'(s2_sq[i]);
      dir[i] = NV_W'($signed({pn[i][CRD_W-1], pn[i]} - {pb[i][CRD_W-1], pb[i]}));
      nin[i] = cmd.nn_start ? nv[i] : dir[i];
    end
  end

  npt_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.nf_start | cmd.nn_start),
    .vin   (nin),
    .done  (n_done),
    .zero  (n_zero),
    .q     (nq)
  );

  assign sts.func       = func_r;
  assign sts.scan_last  = (k == last);
  assign sts.pipe_empty = !(s0_v || s1_v || s2_v);
  assign sts.norm_done  = n_done;
  assign sts.norm_zero  = n_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_reg <= CNT_W'(1);
      s0_v    <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cnt_reg <= cfg_wdata;
      end
      s0_v <= cmd.scan_inc;
      s1_v <= s0_v;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s0_k <= k;
    s1_k <= s0_k;
    s2_k <= s1_k;
    for (int i = 0; i < 3; i++) begin
      s1_m[i]  <= mag[i];
      s2_sq[i] <= sq[i];
    end
    if (cmd.load) begin
      func_r      <= in_func;
      idx_r       <= in_idx;
      idx_ok      <= in_idx_ok;
      crd[0]      <= in_x;
      crd[1]      <= in_y;
      crd[2]      <= in_z;
      k           <= '0;
      res_closest <= '0;
      res_next    <= '0;
      res_st      <= ST_OK;
      for (int i = 0; i < 3; i++) begin
        res_p[i] <= '0;
        res_f[i] <= '0;
        res_n[i] <= '0;
      end
    end
    if (cmd.scan_inc) begin
      k <= k + 1'b1;
    end
    // lowest index wins a tie: replace only on a strictly smaller distance
    if (s2_v && ((s2_k == '0) || (dsum < best_d))) begin
      best_k <= s2_k;
      best_d <= dsum;
    end
    if (cmd.cap_point && idx_ok) begin
      for (int i = 0; i < 3; i++) begin
        res_p[i] <= rp[i];
      end
    end
    if (cmd.cap_best) begin
      for (int i = 0; i < 3; i++) begin
        pb[i] <= rp[i];
      end
    end
    if (cmd.cap_next) begin
      res_closest <= best_wide[IDX_W-1:0];
      res_next    <= nxt_wide[IDX_W-1:0];
      for (int i = 0; i < 3; i++) begin
        pn[i]    <= rp[i];
        res_p[i] <= rp[i];
      end
    end
    if (cmd.cap_fwd) begin
      for (int i = 0; i < 3; i++) begin
        res_f[i] <= nq[i];
      end
    end
    if (cmd.st_dir) begin
      res_st <= ST_DIR_ZERO;
    end
    if (cmd.nv_cap) begin
      nv[0] <= -NV_W'(pxy);
      nv[1] <= NV_W'(pxx) + NV_W'(pzz);
      nv[2] <= -NV_W'(pyz);
    end
    if (cmd.cap_nrm) begin
      for (int i = 0; i < 3; i++) begin
        res_n[i] <= nq[i];
      end
    end
    if (cmd.st_nrm) begin
      res_st <= ST_NRM_ZERO;
    end
    if (cmd.out_load) begin
      closest_index <= res_closest;
      next_index    <= res_next;
      point_x       <= res_p[0];
      point_y       <= res_p[1];
      point_z       <= res_p[2];
      forward_x     <= res_f[0];
      forward_y     <= res_f[1];
      forward_z     <= res_f[2];
      normal_x      <= res_n[0];
      normal_y      <= res_n[1];
      normal_z      <= res_n[2];
      status        <= res_st;
    end
  end
endmodule

FILE: src/npt_ctrl.sv
// Controller state machine: sequences items and drives datapath commands.
`include "assert_macros.svh"
module npt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output npt_pkg::cmd_t cmd,
  input  npt_pkg::sts_t sts
);
  import npt_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_DISP  = 15'h0002,
    S_RDISS = 15'h0004,
    S_RDCAP = 15'h0008,
    S_SCAN  = 15'h0010,
    S_DRAIN = 15'h0020,
    S_BEST  = 15'h0040,
    S_NEXT  = 15'h0080,
    S_CAPN  = 15'h0100,
    S_NFS   = 15'h0200,
    S_NFW   = 15'h0400,
    S_NPREP = 15'h0800,
    S_NNS   = 15'h1000,
    S_NNW   = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.addr_sel = AS_IDX;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_WRITE: state_next = S_FIN;
          FN_READ:  state_next = S_RDISS;
          FN_QUERY: state_next = S_SCAN;
          default:  state_next = S_FIN;
        endcase
      end
      S_RDISS: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RDCAP;
      end
      S_RDCAP: begin
        cmd.cap_point = 1'b1;
        state_next    = S_FIN;
      end
      S_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = AS_SCAN;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = S_BEST;
        end
      end
      S_BEST: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = AS_BEST;
        state_next   = S_NEXT;
      end
      S_NEXT: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = AS_NEXT;
        cmd.cap_best = 1'b1;
        state_next   = S_CAPN;
      end
      S_CAPN: begin
        cmd.cap_next = 1'b1;
        state_next   = S_NFS;
      end
      S_NFS: begin
        cmd.nf_start = 1'b1;
        state_next   = S_NFW;
      end
      S_NFW: begin
        if (sts.norm_done) begin
          if (sts.norm_zero) begin
            cmd.st_dir = 1'b1;
            state_next = S_FIN;
          end else begin
            cmd.cap_fwd = 1'b1;
            state_next  = S_NPREP;
          end
        end
      end
      S_NPREP: begin
        cmd.nv_cap = 1'b1;
        state_next = S_NNS;
      end
      S_NNS: begin
        cmd.nn_start = 1'b1;
        state_next   = S_NNW;
      end
      S_NNW: begin
        if (sts.norm_done) begin
          if (sts.norm_zero) begin
            cmd.st_nrm = 1'b1;
          end else begin
            cmd.cap_nrm = 1'b1;
          end
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `NPT_ASSERT_NXT(a_fin_hold, state == S_FIN && rsp_valid && !rsp_ready, state == S_FIN, "result overwritten while stalled")
  `NPT_ASSERT_NXT(a_scan_drain, state == S_SCAN && sts.scan_last, state == S_DRAIN && !sts.pipe_empty, "scan pipeline lost the last point")
  `NPT_ASSERT(a_norm_wait, sts.norm_done |-> (state == S_NFW || state == S_NNW), "normalizer finished outside a wait state")
endmodule

FILE: src/nearest_path_point_tracker_top.sv
// Top level of the nearest path point tracker.
// Usage:
//   req channel carries one beat per item: func selects write point, read point or
//   query nearest; point_index addresses the store; coord_x/y/z are Q16.16.
//   rsp channel returns exactly one beat per request beat, in order.
//   cfg_we/cfg_wdata write point_count; write it only while the block is idle.
// Operation (one item in flight at a time):
//   write stores the point as the request beat is taken; read fetches the entry from
//   the store and captures it. query runs the distance scan and the point fetches,
//   then two normalizer passes (a shift search, then 15 square-and-multiply rounds),
//   with the normal setup between them and the result load after them; the second
//   pass is skipped when the direction has zero length.
//   The scan reads one stored point per cycle from the single RAM read port.
// Reset clears the controller and the result valid flag and sets point_count to 1;
//   the point store is not cleared, so read only entries already written.
// A stalled rsp holds its beat; the next request beat is still taken and worked
//   on, and its result waits until the held beat leaves.
module nearest_path_point_tracker_top #(
  parameter int MAX_POINTS = npt_pkg::MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [npt_pkg::CNT_W-1:0] cfg_wdata,
  npt_req_if.sink                   req,
  npt_rsp_if.source                 rsp
);
  import npt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence each item and own the handshakes
  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // store, scan pipeline, normalizer and result beat registers
  npt_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_func       (req.func),
    .in_idx        (req.point_index),
    .in_x          (req.coord_x),
    .in_y          (req.coord_y),
    .in_z          (req.coord_z),
    .cmd           (cmd),
    .sts           (sts),
    .closest_index (rsp.closest_index),
    .next_index    (rsp.next_index),
    .point_x       (rsp.point_x),
    .point_y       (rsp.point_y),
    .point_z       (rsp.point_z),
    .forward_x     (rsp.forward_x),
    .forward_y     (rsp.forward_y),
    .forward_z     (rsp.forward_z),
    .normal_x      (rsp.normal_x),
    .normal_y      (rsp.normal_y),
    .normal_z      (rsp.normal_z),
    .status        (rsp.status)
  );
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the nearest path point tracker: its own model, random traffic, stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import npt_pkg::*;

  // One request beat as the bench queues it for the driver.
  typedef struct packed {
    func_t                   func;
    logic [IDX_W-1:0]        idx;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } req_beat_t;

  // One response beat, in the order the bench compares it.
  typedef struct packed {
    logic [IDX_W-1:0]        closest;
    logic [IDX_W-1:0]        next;
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    logic signed [CRD_W-1:0] pz;
    logic signed [Q_W-1:0]   fx;
    logic signed [Q_W-1:0]   fy;
    logic signed [Q_W-1:0]   fz;
    logic signed [Q_W-1:0]   nx;
    logic signed [Q_W-1:0]   ny;
    logic signed [Q_W-1:0]   nz;
    status_t                 status;
  } rsp_beat_t;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int MAXP        = MAX_POINTS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  npt_req_if req();
  npt_rsp_if rsp();

  nearest_path_point_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench copy of the path store and the count register.
  logic signed [CRD_W-1:0] path_x [MAXP];
  logic signed [CRD_W-1:0] path_y [MAXP];
  logic signed [CRD_W-1:0] path_z [MAXP];
  logic [CNT_W-1:0]        count_shadow = 7'd1;

  req_beat_t pending_beats[$];
  rsp_beat_t expected_beats[$];

  int  errors = 0;
  int  cycles = 0;
  int  n_query = 0, n_dir_zero = 0, n_nrm_zero = 0, n_read = 0, n_write = 0;
  bit  idle_on = 1'b1;
  int  rsp_hold = 0;
  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  int  req_gap = 0;
  int  rsp_wait = 0;

  // Scale a 3-vector to a Q2.14 unit vector; returns 0 when the vector is all zero.
  function automatic bit unit_q14(input longint v0, input longint v1, input longint v2,
                                  output logic [Q_W-1:0] o0, output logic [Q_W-1:0] o1,
                                  output logic [Q_W-1:0] o2);
    longint       v[3];
    logic [63:0]  m[3];
    logic [63:0]  mx, l2, lo, hi, mid;
    logic [127:0] lhs, rhs;
    logic [Q_W-1:0] o[3];
    int sh;
    v[0] = v0; v[1] = v1; v[2] = v2;
    mx = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    o0 = '0; o1 = '0; o2 = '0;
    if (mx == 0) return 1'b0;
    sh = 0;
    while ((mx >> sh) >= 64'd65536) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> sh;
      l2 += m[i] * m[i];
    end
    // Round-half-away result as the largest q whose lower rounding edge still fits.
    for (int i = 0; i < 3; i++) begin
      lo = 0;
      hi = UNIT_Q14;
      rhs = 128'(m[i] * m[i]) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(l2);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      o[i] = (v[i] < 0) ? Q_W'(-lo) : Q_W'(lo);
    end
    o0 = o[0]; o1 = o[1]; o2 = o[2];
    return 1'b1;
  endfunction

  // Work out the response for one accepted request and update the store copy.
  function automatic rsp_beat_t predict_beat(input req_beat_t b);
    rsp_beat_t   r;
    int          cnt, best, nxt;
    logic [67:0] sum_sq, best_dist;
    longint      d;
    longint      fxl, fyl, fzl;
    logic [Q_W-1:0] f0, f1, f2, n0, n1, n2;
    r = '0;
    case (b.func)
      FN_WRITE: begin
        n_write++;
        path_x[b.idx] = b.x;
        path_y[b.idx] = b.y;
        path_z[b.idx] = b.z;
      end
      FN_READ: begin
        n_read++;
        r.px = path_x[b.idx];
        r.py = path_y[b.idx];
        r.pz = path_z[b.idx];
      end
      FN_QUERY: begin
        n_query++;
        cnt = (count_shadow == 0) ? 1 : (count_shadow > MAXP) ? MAXP : count_shadow;
        best = 0;
        best_dist = '0;
        for (int k = 0; k < cnt; k++) begin
          sum_sq = '0;
          d = longint'(b.x) - longint'(path_x[k]); sum_sq += 68'(d * d);
          d = longint'(b.y) - longint'(path_y[k]); sum_sq += 68'(d * d);
          d = longint'(b.z) - longint'(path_z[k]); sum_sq += 68'(d * d);
          // strict compare keeps the lowest index on a tie
          if (k == 0 || sum_sq < best_dist) begin
            best = k;
            best_dist = sum_sq;
          end
        end
        nxt = (best + 1 == cnt) ? 0 : best + 1;
        r.closest = IDX_W'(best);
        r.next = IDX_W'(nxt);
        r.px = path_x[nxt];
        r.py = path_y[nxt];
        r.pz = path_z[nxt];
        if (!unit_q14(longint'(path_x[nxt]) - longint'(path_x[best]),
                      longint'(path_y[nxt]) - longint'(path_y[best]),
                      longint'(path_z[nxt]) - longint'(path_z[best]), f0, f1, f2)) begin
          r.status = ST_DIR_ZERO;
          n_dir_zero++;
        end else begin
          r.fx = f0; r.fy = f1; r.fz = f2;
          fxl = longint'($signed(f0));
          fyl = longint'($signed(f1));
          fzl = longint'($signed(f2));
          if (!unit_q14(-(fxl * fyl), fxl * fxl + fzl * fzl, -(fyl * fzl), n0, n1, n2)) begin
            r.status = ST_NRM_ZERO;
            n_nrm_zero++;
          end else begin
            r.nx = n0; r.ny = n1; r.nz = n2;
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Coordinate mix: rails, zero, small fractions, full range.
  function automatic logic signed [CRD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return $signed($urandom_range(0, 20 << 16)) - (10 <<< 16);
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic req_beat_t mk_beat(input func_t f, input int idx,
                                        input logic signed [CRD_W-1:0] x,
                                        input logic signed [CRD_W-1:0] y,
                                        input logic signed [CRD_W-1:0] z);
    req_beat_t b;
    b.func = f;
    b.idx = IDX_W'(idx);
    b.x = x; b.y = y; b.z = z;
    return b;
  endfunction

  // Request driver: change at the falling edge, drop valid after a beat, then wait a random gap while idle_on is set.
  always @(negedge clk) begin
    if (rst) begin
      req.valid = 1'b0;
      req.func = FN_WRITE;
      req.point_index = '0;
      req.coord_x = '0;
      req.coord_y = '0;
      req.coord_z = '0;
    end else begin
      if (req_fire) begin
        req.valid = 1'b0;
        req_gap = idle_on ? $urandom_range(0, 10) : 0;
      end
      if (!req.valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_beats.size() > 0) begin
          req_beat_t b;
          b = pending_beats.pop_front();
          req.func = b.func;
          req.point_index = b.idx;
          req.coord_x = b.x;
          req.coord_y = b.y;
          req.coord_z = b.z;
          req.valid = 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(negedge clk) begin
    if (rsp_hold > 0) rsp_hold <= rsp_hold - 1;
  end

  // Response ready: a fresh random stall after every beat while idle_on is set, plus the long hold.
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready = 1'b0;
    end else begin
      if (rsp_fire) rsp_wait = idle_on ? $urandom_range(0, 10) : 0;
      if (rsp_hold > 0) begin
        rsp.ready = 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp.ready = 1'b0;
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  // Monitor: predict on each request beat, check each response beat in order.
  always @(posedge clk) begin
    req_fire <= !rst && req.valid && req.ready;
    rsp_fire <= !rst && rsp.valid && rsp.ready;
    if (!rst && req.valid && req.ready)
      expected_beats.push_back(predict_beat(mk_beat(req.func, req.point_index,
                                                    req.coord_x, req.coord_y, req.coord_z)));
    if (!rst && rsp.valid && rsp.ready) begin
      rsp_beat_t got, want;
      got.closest = rsp.closest_index;
      got.next = rsp.next_index;
      got.px = rsp.point_x;
      got.py = rsp.point_y;
      got.pz = rsp.point_z;
      got.fx = rsp.forward_x;
      got.fy = rsp.forward_y;
      got.fz = rsp.forward_z;
      got.nx = rsp.normal_x;
      got.ny = rsp.normal_y;
      got.nz = rsp.normal_z;
      got.status = rsp.status;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d beats outstanding", expected_beats.size());
      $display("nearest_path_point_tracker_top test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    wait (pending_beats.size() == 0 && !req.valid && expected_beats.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_count(input int value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = CNT_W'(value);
    count_shadow = CNT_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random traffic: half queries, mostly near the path, with writes, reads and unused func.
  task automatic random_phase(input int n_items);
    int k, cnt, pick;
    logic signed [CRD_W-1:0] ox, oy, oz;
    cnt = (count_shadow == 0) ? 1 : (count_shadow > MAXP) ? MAXP : count_shadow;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, cnt - 1);
      if (pick < 25) begin
        pending_beats.push_back(mk_beat(FN_WRITE, $urandom_range(0, MAXP - 1),
                                        pick_coord(), pick_coord(), pick_coord()));
      end else if (pick < 45) begin
        pending_beats.push_back(mk_beat(FN_READ, $urandom_range(0, MAXP - 1), 0, 0, 0));
      end else if (pick < 95) begin
        // aim near a path point most of the time, sometimes anywhere
        if ($urandom_range(0, 3) != 0) begin
          ox = path_x[k] + ($signed($urandom_range(0, 1 << 17)) - (1 <<< 16));
          oy = path_y[k] + ($signed($urandom_range(0, 1 << 17)) - (1 <<< 16));
          oz = path_z[k] + ($signed($urandom_range(0, 1 << 17)) - (1 <<< 16));
        end else begin
          ox = pick_coord(); oy = pick_coord(); oz = pick_coord();
        end
        pending_beats.push_back(mk_beat(FN_QUERY, $urandom_range(0, MAXP - 1), ox, oy, oz));
      end else begin
        pending_beats.push_back(mk_beat(func_t'(3), $urandom_range(0, MAXP - 1),
                                        $signed($urandom()), $signed($urandom()),
                                        $signed($urandom())));
      end
      // keep the store copy in step for targeting: writes land only when accepted
      if (pending_beats.size() > 8) wait (pending_beats.size() <= 8);
    end
  endtask

  initial begin
    int counts[6];
    for (int i = 0; i < MAXP; i++) begin
      path_x[i] = '0; path_y[i] = '0; path_z[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole store first so no read or query ever touches an unwritten entry.
    for (int i = 0; i < MAXP; i++)
      pending_beats.push_back(mk_beat(FN_WRITE, i, $signed($urandom()), $signed($urandom()),
                                      $signed($urandom())));
    // Count of one at reset: direction is always zero.
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 0, 0));
    wait_drained();

    // Directed path: vertical step, duplicate points, rail-to-rail span.
    pending_beats.push_back(mk_beat(FN_WRITE, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(FN_WRITE, 1, 0, 32'sh0001_0000, 0));
    pending_beats.push_back(mk_beat(FN_WRITE, 2, 0, 32'sh0001_0000, 0));
    pending_beats.push_back(mk_beat(FN_WRITE, 3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    pending_beats.push_back(mk_beat(FN_WRITE, 4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    pending_beats.push_back(mk_beat(FN_WRITE, 5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001));
    pending_beats.push_back(mk_beat(FN_READ, 3, 0, 0, 0));
    pending_beats.push_back(mk_beat(FN_READ, 63, 0, 0, 0));
    pending_beats.push_back(mk_beat(func_t'(3), 63, -1, -1, -1));
    set_count(6);
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 0, 0));
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 32'sh0001_0000, 0));
    pending_beats.push_back(mk_beat(FN_QUERY, 63, 32'sh8000_0000, 32'sh8000_0000,
                                    32'sh8000_0000));
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                    32'sh7FFF_FFFF));
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    // Halfway between two points: tie goes to the lower index.
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 32'sh0000_8000, 0));
    set_count(0);
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 5, 5, 5));
    set_count(2);
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 32'sh0001_0000, 0));
    set_count(127);
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1));
    set_count(64);
    pending_beats.push_back(mk_beat(FN_QUERY, 0, 0, 0, 0));

    // Long receiver hold-off while the sender keeps offering beats.
    set_count(4);
    @(posedge clk);
    rsp_hold = 600;
    random_phase(40);

    // Mostly short paths, a few at the full size and the extremes of the register.
    counts = '{2, 3, 5, 8, 64, 127};
    for (int ph = 0; ph < 12; ph++) begin
      set_count((ph % 4 == 3) ? counts[4 + (ph / 4) % 2] : counts[$urandom_range(0, 3)]);
      idle_on = (ph % 3 != 2);
      random_phase((ph % 4 == 3) ? 30 : 85);
    end
    idle_on = 1'b1;
    set_count(1);
    random_phase(40);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d queries", n_write, n_read, n_query);
    $display("queries with zero direction %0d, vertical direction %0d, mismatches %0d",
             n_dir_zero, n_nrm_zero, errors);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("nearest_path_point_tracker_top test passed");
    end else begin
      $display("nearest_path_point_tracker_top test failed");
    end
    $finish;
  end

endmodule
